// File: rtl/core/mnva_pkg.sv
`default_nettype none

package mnva_pkg;

    // MIDI byte decoding
    localparam logic [7:0] STATUS_BIT   = 8'h80;
    localparam logic [7:0] COMMAND_MASK = 8'hf0;
    localparam logic [7:0] CMD_NOTE_OFF = 8'd128;
    localparam logic [7:0] CMD_NOTE_ON  = 8'd144;

    // payload widths
    localparam int NOTE_W  = 7;
    localparam int ORDER_W = 32;
    localparam int PITCH_SHIFT = 9;
    localparam logic [15:0] GATE_FULL = 16'hffff;
    localparam logic [15:0] GATE_OFF  = 16'h0000;

    // controller to datapath
    typedef struct packed {
        logic take_byte;   // input item accepted this cycle
        logic walk_run;    // step the voice scan
        logic commit;      // apply chosen voice and load the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic starts_op;   // current byte completes a note on/off pair
        logic walk_done;   // last voice is being scanned this cycle
        logic out_free;    // output register can take a new item
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/mnva_ram.sv
`default_nettype none

module mnva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/mnva_ctrl.sv
`default_nettype none

module mnva_ctrl
    import mnva_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_COMMIT
    } t_state;

    t_state r_state;

    // sequencer: take byte, scan voices, commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_stat.starts_op) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_stat.walk_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_cmd.take_byte  = i_valid && (r_state == S_IDLE);
    assign o_cmd.walk_run   = (r_state == S_WALK);
    assign o_cmd.commit     = (r_state == S_COMMIT) && i_stat.out_free;

endmodule

`default_nettype wire

// File: rtl/core/mnva_datapath.sv
`default_nettype none

module mnva_datapath
    import mnva_pkg::*;
#(
    parameter int VOICES = 8,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_midi_byte,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic        i_out_stall,
    output logic             o_valid,
    output logic [2:0]       o_voice_index,
    output logic [15:0]      o_pitch_value,
    output logic [15:0]      o_gate_value,
    output logic             o_is_start
);

    localparam int RAM_W = NOTE_W + ORDER_W;
    localparam logic [VW:0] LAST_ADDR = (VW+1)'(VOICES);

    // parser state
    logic [7:0]        r_cmd;
    logic [NOTE_W-1:0] r_pend_note;
    logic              r_have_pend;
    logic              r_op_start;
    logic [NOTE_W-1:0] r_op_note;

    // voice state
    logic               r_active  [VOICES];
    logic               r_written [VOICES];
    logic [ORDER_W-1:0] r_start_cnt;
    logic [ORDER_W-1:0] r_end_cnt;

    // scan state
    logic [VW:0]        r_addr;
    logic               r_lag_valid;
    logic [VW-1:0]      r_lag_idx;
    logic               r_match_found;
    logic [VW-1:0]      r_match_idx;
    logic               r_free_found;
    logic [VW-1:0]      r_free_idx;
    logic [ORDER_W-1:0] r_free_order;
    logic               r_act_found;
    logic [VW-1:0]      r_act_idx;
    logic [ORDER_W-1:0] r_act_order;

    // output register
    logic              r_out_valid;
    logic [2:0]        r_out_idx;
    logic [15:0]       r_out_pitch;
    logic [15:0]       r_out_gate;
    logic              r_out_start;

    logic              is_status;
    logic              note_cmd;
    logic              rd_en;
    logic [RAM_W-1:0]  rd_data;
    logic [NOTE_W-1:0] rd_note;
    logic [ORDER_W-1:0] rd_order;
    logic              lag_active;
    logic              commit_hit;
    logic [VW-1:0]     sel_idx;
    logic [ORDER_W-1:0] new_order;
    logic              out_take;

    assign is_status = i_midi_byte[7];
    assign note_cmd  = (r_cmd == CMD_NOTE_ON) || (r_cmd == CMD_NOTE_OFF);

    // read side of the scan
    assign rd_en      = i_cmd.walk_run && (r_addr != LAST_ADDR);
    assign rd_note    = rd_data[RAM_W-1:ORDER_W];
    assign rd_order   = r_written[r_lag_idx] ? rd_data[ORDER_W-1:0] : '0;
    assign lag_active = r_active[r_lag_idx];

    // voice choice: held note, then oldest free, then oldest active; a note off takes only the held note
    always_comb begin
        if (r_op_start) begin
            commit_hit = 1'b1;
            if (r_match_found) begin
                sel_idx = r_match_idx;
            end else if (r_free_found) begin
                sel_idx = r_free_idx;
            end else begin
                sel_idx = r_act_idx;
            end
            new_order = r_start_cnt + 1'b1;
        end else begin
            commit_hit = r_match_found;
            sel_idx    = r_match_idx;
            new_order  = r_end_cnt + 1'b1;
        end
    end

    mnva_ram #(
        .WIDTH (RAM_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && commit_hit),
        .i_waddr (sel_idx),
        .i_wdata ({r_op_note, new_order}),
        .i_re    (rd_en),
        .i_raddr (r_addr[VW-1:0]),
        .o_rdata (rd_data)
    );

    // byte parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= '0;
            r_have_pend <= 1'b0;
        end else if (i_cmd.take_byte) begin
            if (is_status) begin
                r_cmd       <= i_midi_byte & COMMAND_MASK;
                r_have_pend <= 1'b0;
            end else if (note_cmd) begin
                r_have_pend <= !r_have_pend;
            end
        end
    end

    // note and op latches
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && !is_status && note_cmd) begin
            if (!r_have_pend) begin
                r_pend_note <= i_midi_byte[NOTE_W-1:0];
            end else begin
                r_op_note  <= r_pend_note;
                r_op_start <= (r_cmd == CMD_NOTE_ON) && (i_midi_byte != 8'd0);
            end
        end
    end

    // scan address and read lag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_lag_valid <= 1'b0;
        end else if (o_stat.starts_op && i_cmd.take_byte) begin
            r_addr      <= '0;
            r_lag_valid <= 1'b0;
        end else if (i_cmd.walk_run) begin
            r_lag_valid <= rd_en;
            if (rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_lag_idx <= r_addr[VW-1:0];
        end
    end

    // running match and oldest-voice trackers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_act_found   <= 1'b0;
        end else if (i_cmd.walk_run && r_lag_valid) begin
            if (lag_active && (rd_note == r_op_note) && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_lag_idx;
            end
            if (!lag_active && (!r_free_found || (rd_order < r_free_order))) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_lag_idx;
                r_free_order <= rd_order;
            end
            if (lag_active && (!r_act_found || (rd_order < r_act_order))) begin
                r_act_found <= 1'b1;
                r_act_idx   <= r_lag_idx;
                r_act_order <= rd_order;
            end
        end
    end

    // voice flags and order counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_active[v]  <= 1'b0;
                r_written[v] <= 1'b0;
            end
            r_start_cnt <= '0;
            r_end_cnt   <= '0;
        end else if (i_cmd.commit && commit_hit) begin
            r_active[sel_idx]  <= r_op_start;
            r_written[sel_idx] <= 1'b1;
            if (r_op_start) begin
                r_start_cnt <= new_order;
            end else begin
                r_end_cnt <= new_order;
            end
        end
    end

    // output register
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && commit_hit) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && commit_hit) begin
            r_out_idx   <= 3'(sel_idx);
            r_out_pitch <= {r_op_note, {PITCH_SHIFT{1'b0}}};
            r_out_gate  <= r_op_start ? GATE_FULL : GATE_OFF;
            r_out_start <= r_op_start;
        end
    end

    assign o_stat.starts_op = !is_status && note_cmd && r_have_pend;
    assign o_stat.walk_done = (r_addr == LAST_ADDR);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_valid       = r_out_valid;
    assign o_voice_index = r_out_idx;
    assign o_pitch_value = r_out_pitch;
    assign o_gate_value  = r_out_gate;
    assign o_is_start    = r_out_start;

endmodule

`default_nettype wire

// File: rtl/core/midi_note_voice_allocator.sv
`default_nettype none

// MIDI note on/off voice allocator. Takes one raw MIDI byte per input item and
// gives at most one result item: the voice whose pitch and gate changed. Status
// bytes and bytes that do not finish a note/velocity pair are taken while the sequencer
// is idle and start no scan. A byte that finishes a pair makes the sequencer scan the
// per-voice note/order memory once, one voice per cycle through its single registered
// read port, tracking the held note, the oldest released voice and the oldest started
// voice at the same time, then commit the choice once the output register is free. A
// finished result sits in an output register, so the next byte is taken while it waits;
// a further result waits for it to drain.
// Voice index output carries the low three bits of the voice number.
module midi_note_voice_allocator
    import mnva_pkg::*;
#(
    parameter int VOICES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_midi_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_voice_index,
    output logic [15:0]      o_pitch_value,
    output logic [15:0]      o_gate_value,
    output logic             o_is_start
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mnva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    mnva_datapath #(
        .VOICES (VOICES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_midi_byte   (i_midi_byte),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_out_stall   (i_stall),
        .o_valid       (o_valid),
        .o_voice_index (o_voice_index),
        .o_pitch_value (o_pitch_value),
        .o_gate_value  (o_gate_value),
        .o_is_start    (o_is_start)
    );

endmodule

`default_nettype wire

// File: rtl/core/mnva_checker.sv
`default_nettype none

module mnva_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_voice_index,
    input wire logic [15:0] o_pitch_value,
    input wire logic [15:0] o_gate_value,
    input wire logic        o_is_start
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_voice_index) &&
        $stable(o_pitch_value) && $stable(o_gate_value) && $stable(o_is_start))
        else $error("result changed while stalled");

    // gate level follows start/stop
    a_gate_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_start ? (o_gate_value == 16'hffff) : (o_gate_value == 16'h0000)))
        else $error("gate does not match start flag");

    // pitch is a note shifted into the top bits
    a_pitch_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_value[8:0] == 9'd0))
        else $error("pitch low bits not clear");

    // a new result only comes out of a busy scan
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a note op in progress");

endmodule

bind midi_note_voice_allocator mnva_checker u_mnva_checker (.*);

`default_nettype wire
